[rtl/core/rfae_pkg.sv]
// Package for the register file ALU executor: opcodes, widths, item types.
// No dependencies.
`default_nettype none
package rfae_pkg;
   localparam int RegCount  = 8;
   localparam int IdxWidth  = 3;
   localparam int DataWidth = 64;
   localparam int CntWidth  = 7;

   typedef enum logic [3:0] {
      OP_IN = 4'd0, OP_MOV = 4'd1, OP_XCHG = 4'd2, OP_ADD = 4'd3, OP_SUB = 4'd4,
      OP_MUL = 4'd5, OP_DIV = 4'd6, OP_MOD = 4'd7, OP_AND = 4'd8, OP_OR = 4'd9,
      OP_XOR = 4'd10, OP_OUT = 4'd11
   } op_type;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_DIVZER = 1'b1;

   typedef struct packed {
      logic [63:0] immediate;
      logic        three_operand;
      logic [2:0]  src_b_reg;
      logic [2:0]  src_a_reg;
      logic [2:0]  dest_reg;
      logic [3:0]  operation;
   } req_type;
endpackage
`default_nettype wire

[rtl/core/register_file_alu_executor.sv]
// Top level of the register file ALU executor: register file, serial ALU, output register.
// Depends on rfae_pkg.
// In, mov, xchg, add, sub, and, or, xor execute in ST_EXEC and write back at its end;
// an out or divide-by-zero result is loaded into the output register from ST_EXEC.
// Mul (shift and add) and div, mod (restoring) take one bit per cycle, written in ST_FIN.
// One item at a time: the next item is taken only in ST_IDLE, never while a result waits
// in the output register. Synchronous reset clears state, output valid and register file.
`default_nettype none
module register_file_alu_executor (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // operation[3:0], dest_reg[6:4], src_a_reg[9:7], src_b_reg[12:10],
   // three_operand[13], immediate[77:14], zero[79:78]
   input  wire  [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // value[63:0]
   output logic [63:0] rsp_tdata,
   // status[0]
   output logic        rsp_tuser
);
   import rfae_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_EXEC = 5'b00010, ST_MUL = 5'b00100,
      ST_DIV = 5'b01000, ST_FIN = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   logic [63:0] regs_ff [RegCount];
   logic [63:0] x_ff, x_in, y_ff, y_in, acc_ff, acc_in, quo_ff, quo_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic        ovalid_ff, ovalid_in, ostat_ff, ostat_in;
   logic [63:0] odata_ff, odata_in;
   logic        wr_en, wr2_en;
   logic [IdxWidth-1:0] wr_idx, wr2_idx;
   logic [63:0] wr_val, wr2_val;
   req_type req;
   logic [63:0] rd_d, rd_a, rd_b, opx, opy;
   logic [64:0] trial;

   assign req = req_type'(req_tdata[77:0]);
   assign req_tready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ostat_ff;

   assign rd_d = regs_ff[item_ff.dest_reg];
   assign rd_a = regs_ff[item_ff.src_a_reg];
   assign rd_b = regs_ff[item_ff.src_b_reg];
   assign opx  = item_ff.three_operand ? rd_a : rd_d;
   assign opy  = item_ff.three_operand ? rd_b : rd_a;
   assign trial = {acc_ff, quo_ff[63]} - {1'b0, y_ff};

   // Control, serial datapath and output register
   always_comb begin
      state_in = state_ff; item_in = item_ff;
      x_in = x_ff; y_in = y_ff; acc_in = acc_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      neg_q_in = neg_q_ff; neg_r_in = neg_r_ff;
      ovalid_in = ovalid_ff && !rsp_tready; ostat_in = ostat_ff; odata_in = odata_ff;
      wr_en = 1'b0; wr_idx = item_ff.dest_reg; wr_val = '0;
      wr2_en = 1'b0; wr2_idx = item_ff.src_a_reg; wr2_val = rd_d;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               item_in = req;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            x_in = opx; y_in = opy; cnt_in = '0; acc_in = '0;
            case (op_type'(item_ff.operation))
               OP_IN:   begin wr_en = 1'b1; wr_val = item_ff.immediate; end
               OP_MOV:  begin wr_en = 1'b1; wr_val = rd_a; end
               // exchange with itself leaves the register as it is
               OP_XCHG: begin
                  wr_en = 1'b1; wr_val = rd_a;
                  wr2_en = (item_ff.src_a_reg != item_ff.dest_reg);
               end
               OP_ADD:  begin wr_en = 1'b1; wr_val = opx + opy; end
               OP_SUB:  begin wr_en = 1'b1; wr_val = opx - opy; end
               OP_AND:  begin wr_en = 1'b1; wr_val = opx & opy; end
               OP_OR:   begin wr_en = 1'b1; wr_val = opx | opy; end
               OP_XOR:  begin wr_en = 1'b1; wr_val = opx ^ opy; end
               OP_MUL:  state_in = ST_MUL;
               OP_DIV, OP_MOD: begin
                  if (opy == '0) begin
                     ovalid_in = 1'b1; odata_in = '0; ostat_in = STATUS_DIVZER;
                  end else begin
                     neg_q_in = opx[63] ^ opy[63];
                     neg_r_in = opx[63];
                     quo_in = opx[63] ? -opx : opx;
                     y_in   = opy[63] ? -opy : opy;
                     state_in = ST_DIV;
                  end
               end
               OP_OUT: begin
                  ovalid_in = 1'b1; odata_in = rd_d; ostat_in = STATUS_OK;
               end
               default: ;
            endcase
         end
         // shift and add, one multiplier bit per cycle
         ST_MUL: begin
            if (y_ff[0]) acc_in = acc_ff + x_ff;
            x_in = x_ff << 1;
            y_in = y_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntWidth'(DataWidth - 1)) state_in = ST_FIN;
         end
         // restoring division, one quotient bit per cycle
         ST_DIV: begin
            if (!trial[64]) begin
               acc_in = trial[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               acc_in = {acc_ff[62:0], quo_ff[63]};
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntWidth'(DataWidth - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in = ST_IDLE;
            wr_en = 1'b1;
            case (op_type'(item_ff.operation))
               OP_DIV:  wr_val = neg_q_ff ? -quo_ff : quo_ff;
               OP_MOD:  wr_val = neg_r_ff ? -acc_ff : acc_ff;
               default: wr_val = acc_ff;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < RegCount; i++) regs_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         ovalid_ff <= ovalid_in;
         if (wr2_en) regs_ff[wr2_idx] <= wr2_val;
         if (wr_en) regs_ff[wr_idx] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; x_ff <= x_in; y_ff <= y_in; acc_ff <= acc_in;
      quo_ff <= quo_in; cnt_ff <= cnt_in; neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in;
      ostat_ff <= ostat_in; odata_ff <= odata_in;
   end
endmodule
`default_nettype wire

[rtl/core/rfae_checker.sv]
// Port checker for the register file ALU executor, bound to the top level.
// Depends on rfae_pkg.
`default_nettype none
module rfae_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [63:0] rsp_tdata,
   input wire        rsp_tuser
);
   import rfae_pkg::*;

   // a waiting item holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");
   // an error result carries zero
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_DIVZER |-> rsp_tdata == '0)
      else $error("error result with nonzero value");
   // one item at a time: no accept in the cycle after one
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted back to back");
   // no result right out of reset
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind register_file_alu_executor rfae_checker u_rfae_checker (.*);
`default_nettype wire

[dv/register_file_alu_executor_tb.sv]
// Testbench for register_file_alu_executor: directed table then random instruction items,
// checked against an in-bench register file predictor. Depends on rfae_pkg and the RTL.
`timescale 1ns / 100ps
module register_file_alu_executor_tb;
   import rfae_pkg::*;

   typedef struct {
      logic [3:0]  operation;
      logic [2:0]  dest_reg;
      logic [2:0]  src_a_reg;
      logic [2:0]  src_b_reg;
      logic        three_operand;
      logic [63:0] immediate;
      logic        has_exp;       // typed-in expectation present
      logic [63:0] exp_value;
      logic        exp_status;
   } instr_type;

   typedef struct {
      logic [63:0] value;
      logic        status;
   } rsp_type;

   localparam int RandomItems = 1600;
   localparam logic [63:0] MinNeg = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MaxPos = 64'h7fff_ffff_ffff_ffff;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;

   logic [63:0] shadow_regs [RegCount];
   rsp_type     pending_rsp [$];
   int          error_count;
   int          hold_cycles;   // long receiver hold-off, counted by the sink
   bit          calm;          // no random idling on either side

   register_file_alu_executor DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("register_file_alu_executor_tb NOT OK");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("%0t ERROR %s", $realtime, what);
   endtask

   function automatic logic [63:0] abs64(input logic [63:0] v);
      return v[63] ? -v : v;
   endfunction

   // Advance the shadow register file by one instruction; queue any response.
   task automatic execute_instr(input instr_type r);
      logic [63:0] x, y, res, q, m;
      op_type op;
      op = op_type'(r.operation);
      if (r.operation > OP_OUT) return;
      case (op)
         OP_IN: shadow_regs[r.dest_reg] = r.immediate;
         OP_MOV: shadow_regs[r.dest_reg] = shadow_regs[r.src_a_reg];
         OP_XCHG: begin
            x = shadow_regs[r.dest_reg];
            shadow_regs[r.dest_reg] = shadow_regs[r.src_a_reg];
            shadow_regs[r.src_a_reg] = x;
         end
         OP_OUT: pending_rsp.push_back('{shadow_regs[r.dest_reg], STATUS_OK});
         default: begin
            x = r.three_operand ? shadow_regs[r.src_a_reg] : shadow_regs[r.dest_reg];
            y = r.three_operand ? shadow_regs[r.src_b_reg] : shadow_regs[r.src_a_reg];
            if ((op == OP_DIV || op == OP_MOD) && y == 64'd0) begin
               pending_rsp.push_back('{64'd0, STATUS_DIVZER});
               return;
            end
            q = abs64(x) / abs64(y);
            m = abs64(x) % abs64(y);
            case (op)
               OP_ADD: res = x + y;
               OP_SUB: res = x - y;
               OP_MUL: res = x * y;
               OP_DIV: res = (x[63] != y[63]) ? -q : q;
               OP_MOD: res = x[63] ? -m : m;
               OP_AND: res = x & y;
               OP_OR:  res = x | y;
               default: res = x ^ y;
            endcase
            shadow_regs[r.dest_reg] = res;
         end
      endcase
   endtask

   // Hand one item to the block; waits for acceptance.
   task automatic send_instr(input instr_type r);
      while (!calm && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.immediate, r.three_operand, r.src_b_reg,
                     r.src_a_reg, r.dest_reg, r.operation};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (r.has_exp) begin
         if (r.operation == OP_OUT)
            shadow_regs[r.dest_reg] = r.exp_value;   // typed-in row must agree
         execute_instr(r);
         if (pending_rsp.size() > 0) begin
            pending_rsp[$].value  = r.exp_value;
            pending_rsp[$].status = r.exp_status;
         end
      end else begin
         execute_instr(r);
      end
   endtask

   function automatic instr_type mk(input op_type op, input int d, input int a, input int b,
                                    input bit t, input logic [63:0] imm);
      instr_type r;
      r = '{op, d[2:0], a[2:0], b[2:0], t, imm, 1'b0, 64'd0, 1'b0};
      return r;
   endfunction

   function automatic instr_type mkx(input op_type op, input int d, input int b,
                                     input logic [63:0] v, input logic s);
      instr_type r;
      r = mk(op, d, 0, b, 1'b1, 64'd0);
      r.has_exp = 1'b1;
      r.exp_value = v;
      r.exp_status = s;
      return r;
   endfunction

   // Response sink: random stalls, one long hold-off, compare with oldest expectation.
   initial begin
      rsp_type e;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tready && rsp_tvalid) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected item %h/%b", rsp_tdata, rsp_tuser));
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_tdata !== e.value)
                  report_mismatch($sformatf("value %h exp %h", rsp_tdata, e.value));
               if (rsp_tuser !== e.status)
                  report_mismatch($sformatf("status %b exp %b", rsp_tuser, e.status));
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 27);
         end
      end
   end

   initial begin
      instr_type tbl [$];
      instr_type r;
      int n;
      int timeout;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      error_count = 0;
      hold_cycles = 0;
      calm        = 1'b0;
      foreach (shadow_regs[i]) shadow_regs[i] = 64'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset contents, extremes, division by zero, min/-1, remainder sign.
      tbl.push_back(mkx(OP_OUT, 7, 0, 64'd0, STATUS_OK));
      tbl.push_back(mkx(OP_DIV, 1, 2, 64'd0, STATUS_DIVZER));
      tbl.push_back(mk(OP_MOD, 1, 2, 0, 1'b0, 64'd0));
      tbl.push_back(mk(OP_IN, 0, 5, 6, 1'b1, MinNeg));
      tbl.push_back(mk(OP_IN, 1, 0, 0, 1'b0, '1));
      tbl.push_back(mk(OP_IN, 2, 0, 0, 1'b0, MaxPos));
      tbl.push_back(mk(OP_IN, 3, 0, 0, 1'b0, -64'sd7));
      tbl.push_back(mk(OP_IN, 4, 0, 0, 1'b0, 64'd2));
      tbl.push_back(mk(OP_DIV, 5, 0, 1, 1'b1, 64'd0));
      tbl.push_back(mkx(OP_OUT, 5, 0, MinNeg, STATUS_OK));
      tbl.push_back(mk(OP_MOD, 6, 0, 1, 1'b1, 64'd0));
      tbl.push_back(mkx(OP_OUT, 6, 0, 64'd0, STATUS_OK));
      tbl.push_back(mk(OP_MOD, 6, 3, 4, 1'b1, 64'd0));
      tbl.push_back(mkx(OP_OUT, 6, 0, -64'sd1, STATUS_OK));
      tbl.push_back(mk(OP_DIV, 7, 3, 4, 1'b1, 64'd0));
      tbl.push_back(mk(OP_MOV, 5, 2, 0, 1'b1, 64'd0));
      tbl.push_back(mk(OP_XCHG, 5, 3, 0, 1'b0, 64'd0));
      tbl.push_back(mk(OP_XCHG, 4, 4, 0, 1'b0, 64'd0));
      tbl.push_back(mk(OP_ADD, 2, 1, 0, 1'b0, 64'd0));
      tbl.push_back(mk(OP_SUB, 0, 2, 0, 1'b0, 64'd0));
      tbl.push_back(mk(OP_MUL, 6, 2, 2, 1'b1, 64'd0));
      tbl.push_back(mk(OP_AND, 1, 3, 0, 1'b0, 64'd0));
      tbl.push_back(mk(OP_OR, 3, 0, 2, 1'b1, 64'd0));
      tbl.push_back(mk(OP_XOR, 4, 1, 0, 1'b0, 64'd0));
      tbl.push_back(mk(op_type'(4'd15), 0, 7, 7, 1'b1, '1));
      foreach (tbl[i]) send_instr(tbl[i]);
      for (int k = 0; k < 8; k++) send_instr(mk(OP_OUT, k, 0, 0, 1'b0, 64'd0));

      // Receiver holds off while items keep coming.
      hold_cycles = 400;
      for (int k = 0; k < 6; k++) send_instr(mk(OP_OUT, k, 0, 0, 1'b1, 64'd0));

      // Random part; a calm stretch and a drain pause partway.
      for (n = 0; n < RandomItems; n++) begin
         calm = (n >= 500 && n < 700);
         if (n == 900) begin
            req_tvalid <= 1'b0;
            while (pending_rsp.size() != 0) @(posedge clock);
         end
         r = mk(OP_IN, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                $urandom_range(1), {$urandom, $urandom});
         case ($urandom_range(9))
            0: r.immediate = $urandom_range(1) ? MinNeg : MaxPos;
            1: r.immediate = 64'($signed($urandom_range(6)) - 3);
            default: ;
         endcase
         if ($urandom_range(99) < 3)       r.operation = 4'($urandom_range(15, 12));
         else if ($urandom_range(99) < 20) r.operation = OP_OUT;
         else if ($urandom_range(99) < 15) r.operation = OP_IN;
         else                              r.operation = 4'($urandom_range(10, 1));
         send_instr(r);
      end
      calm = 1'b1;
      for (int k = 0; k < 8; k++) send_instr(mk(OP_OUT, k, 0, 0, 1'b0, 64'd0));
      req_tvalid <= 1'b0;

      timeout = 0;
      while (pending_rsp.size() != 0 && timeout < 10000) begin
         @(posedge clock);
         timeout++;
      end
      repeat (80) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("register_file_alu_executor_tb OK");
      else
         $display("register_file_alu_executor_tb NOT OK");
      $finish;
   end
endmodule

[sim.f]
rtl/core/rfae_pkg.sv
rtl/core/register_file_alu_executor.sv
rtl/core/rfae_checker.sv
dv/register_file_alu_executor_tb.sv
